// ===== sv/fxalu_pkg.sv =====
`default_nettype none
package fxalu_pkg;

	localparam int WordWidth  = 32;
	localparam int FracBits   = 8;
	localparam int QuotWidth  = WordWidth + FracBits;
	localparam int ProdWidth  = 2 * WordWidth;
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);

	localparam logic [WordWidth-1:0] MaxPos = {1'b0, {(WordWidth-1){1'b1}}};
	localparam logic [WordWidth-1:0] MinNeg = {1'b1, {(WordWidth-1){1'b0}}};

	// command codes
	localparam logic [3:0] CMD_ADD      = 4'd0;
	localparam logic [3:0] CMD_SUB      = 4'd1;
	localparam logic [3:0] CMD_MUL      = 4'd2;
	localparam logic [3:0] CMD_DIV      = 4'd3;
	localparam logic [3:0] CMD_GT       = 4'd4;
	localparam logic [3:0] CMD_LT       = 4'd5;
	localparam logic [3:0] CMD_GE       = 4'd6;
	localparam logic [3:0] CMD_LE       = 4'd7;
	localparam logic [3:0] CMD_EQ       = 4'd8;
	localparam logic [3:0] CMD_NE       = 4'd9;
	localparam logic [3:0] CMD_MAX      = 4'd10;
	localparam logic [3:0] CMD_MIN      = 4'd11;
	localparam logic [3:0] CMD_INC      = 4'd12;
	localparam logic [3:0] CMD_TO_INT   = 4'd13;
	localparam logic [3:0] CMD_FROM_INT = 4'd14;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_DIV0 = 2'd2;

	typedef struct packed {
		logic [3:0]  command;
		logic [31:0] operand_a;
		logic [31:0] operand_b;
	} cmd_item_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic        compare_true;
		logic [1:0]  status;
	} res_item_t;

	// classified item as held in the queue
	typedef struct packed {
		logic [3:0]           cmd;
		logic [WordWidth-1:0] a;
		logic [WordWidth-1:0] b;
		logic [WordWidth-1:0] ma;
		logic [WordWidth-1:0] mb;
		logic                 neg;
	} work_t;

	// per-item control carried down the back pipeline
	typedef struct packed {
		logic [3:0]           cmd;
		logic                 neg;
		logic                 siga;
		logic                 dvz;
		logic                 maz;
		logic [WordWidth-1:0] res;
		logic                 flag;
		logic [1:0]           st;
	} carry_t;

	function automatic logic [WordWidth-1:0] sat_value(input logic neg);
		return neg ? MinNeg : MaxPos;
	endfunction

endpackage
`default_nettype wire

// ===== sv/fxalu_if.sv =====
`default_nettype none
interface fxalu_cmd_if;
	logic                  valid;
	logic                  ready;
	fxalu_pkg::cmd_item_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface fxalu_res_if;
	logic                  valid;
	logic                  ready;
	fxalu_pkg::res_item_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== sv/fxalu_front.sv =====
`default_nettype none
module fxalu_front (
	fxalu_cmd_if.sink         cmd_ch,
	output fxalu_pkg::work_t  item,
	output logic              item_valid,
	input  logic              item_ready
);
	import fxalu_pkg::*;

	logic [WordWidth-1:0] a_w;
	logic [WordWidth-1:0] b_w;

	// operands taken at word width
	assign a_w = cmd_ch.payload.operand_a[WordWidth-1:0];
	assign b_w = cmd_ch.payload.operand_b[WordWidth-1:0];

	// classify: signs and magnitudes
	always_comb begin
		item.cmd = cmd_ch.payload.command;
		item.a   = a_w;
		item.b   = b_w;
		item.ma  = a_w[WordWidth-1] ? (~a_w + 1'b1) : a_w;
		item.mb  = b_w[WordWidth-1] ? (~b_w + 1'b1) : b_w;
		item.neg = a_w[WordWidth-1] ^ b_w[WordWidth-1];
	end

	assign item_valid   = cmd_ch.valid;
	assign cmd_ch.ready = item_ready;

endmodule
`default_nettype wire

// ===== sv/fxalu_queue.sv =====
`default_nettype none
module fxalu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  fxalu_pkg::work_t  wr_item,
	input  logic              wr_valid,
	output logic              wr_ready,
	output fxalu_pkg::work_t  rd_item,
	output logic              rd_valid,
	input  logic              rd_pop
);
	import fxalu_pkg::*;

	work_t                entry_q [QueueDepth];
	logic [QueuePtrW-1:0] wr_ptr_q;
	logic [QueuePtrW-1:0] rd_ptr_q;
	logic [QueuePtrW:0]   count_q;
	logic                 push;
	logic                 pop;

	assign wr_ready = (count_q != QueueDepth[QueuePtrW:0]);
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_pop && rd_valid;
	assign rd_item  = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= wr_item;
	end

endmodule
`default_nettype wire

// ===== sv/fxalu_back.sv =====
`default_nettype none
module fxalu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  fxalu_pkg::work_t  head,
	input  logic              head_valid,
	output logic              pop,
	fxalu_res_if.source       res_ch
);
	import fxalu_pkg::*;

	localparam int Steps = QuotWidth;

	logic adv;
	logic out_valid_q;

	// stage 1
	logic                 valid_s1;
	carry_t               ctl_s1;
	logic [ProdWidth-1:0] prod_s1;
	logic [WordWidth-1:0] d_s1;
	logic [QuotWidth-1:0] n_s1;
	carry_t               ctl_nx;

	// divider steps, index is the step
	logic                 valid_s [Steps];
	carry_t               ctl_s   [Steps];
	logic [WordWidth-1:0] d_s     [Steps];
	logic [WordWidth-1:0] rem_s   [Steps];
	logic [QuotWidth-1:0] nq_s    [Steps];

	res_item_t            out_q;
	res_item_t            out_nx;

	assign adv            = !out_valid_q || res_ch.ready;
	assign pop            = adv && head_valid;
	assign res_ch.valid   = out_valid_q;
	assign res_ch.payload = out_q;

	// simple operations on the queue head
	always_comb begin
		logic [WordWidth-1:0] sum;
		logic [WordWidth-1:0] dif;
		logic                 sa;
		logic                 sb;
		logic                 gt;
		logic                 lt;
		logic                 eq;
		logic [WordWidth-1:0] lim;
		sa  = head.a[WordWidth-1];
		sb  = head.b[WordWidth-1];
		sum = head.a + head.b;
		dif = head.a - head.b;
		gt  = $signed(head.a) > $signed(head.b);
		lt  = $signed(head.a) < $signed(head.b);
		eq  = head.a == head.b;
		lim = sa ? (MinNeg >> FracBits) : (MaxPos >> FracBits);
		ctl_nx.cmd  = head.cmd;
		ctl_nx.neg  = head.neg;
		ctl_nx.siga = sa;
		ctl_nx.dvz  = (head.mb == '0);
		ctl_nx.maz  = (head.ma == '0);
		ctl_nx.res  = '0;
		ctl_nx.flag = 1'b0;
		ctl_nx.st   = ST_OK;
		case (head.cmd)
			CMD_ADD: begin
				if (sa == sb && sum[WordWidth-1] != sa) begin
					ctl_nx.res = sat_value(sa);
					ctl_nx.st  = ST_OVF;
				end else begin
					ctl_nx.res = sum;
				end
			end
			CMD_SUB: begin
				if (sa != sb && dif[WordWidth-1] != sa) begin
					ctl_nx.res = sat_value(sa);
					ctl_nx.st  = ST_OVF;
				end else begin
					ctl_nx.res = dif;
				end
			end
			CMD_GT: ctl_nx.flag = gt;
			CMD_LT: ctl_nx.flag = lt;
			CMD_GE: ctl_nx.flag = !lt;
			CMD_LE: ctl_nx.flag = !gt;
			CMD_EQ: ctl_nx.flag = eq;
			CMD_NE: ctl_nx.flag = !eq;
			CMD_MAX: ctl_nx.res = gt ? head.a : head.b;
			CMD_MIN: ctl_nx.res = lt ? head.a : head.b;
			CMD_INC: begin
				if (head.a == MaxPos) begin
					ctl_nx.res = MaxPos;
					ctl_nx.st  = ST_OVF;
				end else begin
					ctl_nx.res = head.a + 1'b1;
				end
			end
			CMD_TO_INT: ctl_nx.res = $unsigned($signed(head.a) >>> FracBits);
			CMD_FROM_INT: begin
				if (head.ma > lim) begin
					ctl_nx.res = sat_value(sa);
					ctl_nx.st  = ST_OVF;
				end else begin
					ctl_nx.res = head.a << FracBits;
				end
			end
			default: ;
		endcase
	end

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1  <= ctl_nx;
			prod_s1 <= head.ma * head.mb;
			d_s1    <= head.mb;
			n_s1    <= {head.ma, {FracBits{1'b0}}};
		end
	end

	// one quotient bit per step; first step also rounds the product
	for (genvar k = 0; k < Steps; k++) begin : g_step
		logic                 v_in;
		carry_t               c_in;
		carry_t               c_nx;
		logic [WordWidth-1:0] d_in;
		logic [WordWidth-1:0] rem_in;
		logic [QuotWidth-1:0] nq_in;
		logic [WordWidth:0]   t;
		logic [WordWidth:0]   diff;
		logic                 ge;

		if (k == 0) begin : g_first
			logic [ProdWidth:0]            rnd;
			logic [ProdWidth-FracBits:0]   mag;
			logic [ProdWidth-FracBits:0]   lim;
			assign v_in   = valid_s1;
			assign d_in   = d_s1;
			assign rem_in = '0;
			assign nq_in  = n_s1;
			assign rnd    = {1'b0, prod_s1} + (ProdWidth+1)'(1 << (FracBits - 1));
			assign mag    = rnd[ProdWidth:FracBits];
			assign lim    = (ProdWidth-FracBits+1)'(ctl_s1.neg ? MinNeg : MaxPos);
			always_comb begin
				c_in = ctl_s1;
				if (ctl_s1.cmd == CMD_MUL) begin
					if (mag == '0) begin
						c_in.res = '0;
					end else if (mag > lim) begin
						c_in.res = sat_value(ctl_s1.neg);
						c_in.st  = ST_OVF;
					end else if (ctl_s1.neg) begin
						c_in.res = ~mag[WordWidth-1:0] + 1'b1;
					end else begin
						c_in.res = mag[WordWidth-1:0];
					end
				end
			end
		end else begin : g_next
			assign v_in   = valid_s[k-1];
			assign c_in   = ctl_s[k-1];
			assign d_in   = d_s[k-1];
			assign rem_in = rem_s[k-1];
			assign nq_in  = nq_s[k-1];
		end

		assign c_nx = c_in;
		assign t    = {rem_in, nq_in[QuotWidth-1]};
		assign diff = t - {1'b0, d_in};
		assign ge   = t >= {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (adv) begin
				valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_s[k] <= c_nx;
				d_s[k]   <= d_in;
				rem_s[k] <= ge ? diff[WordWidth-1:0] : t[WordWidth-1:0];
				nq_s[k]  <= {nq_in[QuotWidth-2:0], ge};
			end
		end
	end

	// divide rounding, saturation and result select
	always_comb begin
		carry_t               c;
		logic                 up;
		logic [QuotWidth:0]   q2;
		logic [QuotWidth:0]   lim;
		c   = ctl_s[Steps-1];
		up  = {rem_s[Steps-1], 1'b0} >= {1'b0, d_s[Steps-1]};
		q2  = {1'b0, nq_s[Steps-1]} + {{QuotWidth{1'b0}}, up};
		lim = (QuotWidth+1)'(c.neg ? MinNeg : MaxPos);
		out_nx.result_value = c.res;
		out_nx.compare_true = c.flag;
		out_nx.status       = c.st;
		if (c.cmd == CMD_DIV) begin
			if (c.dvz) begin
				out_nx.status       = ST_DIV0;
				out_nx.result_value = c.maz ? '0 : sat_value(c.siga);
			end else if (q2 == '0) begin
				out_nx.result_value = '0;
			end else if (q2 > lim) begin
				out_nx.result_value = sat_value(c.neg);
				out_nx.status       = ST_OVF;
			end else if (c.neg) begin
				out_nx.result_value = ~q2[WordWidth-1:0] + 1'b1;
			end else begin
				out_nx.result_value = q2[WordWidth-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s[Steps-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) out_q <= out_nx;
	end

endmodule
`default_nettype wire

// ===== sv/fixed_point_q24_8_alu_core.sv =====
// pipeline: an item popped from the queue passes the stage 1 registers, the 40 quotient-bit
// steps of the pipelined divider and the output register; every command passes through them
// throughput: one item per cycle; the front queue holds 4 items and the back
// pipeline stalls as a whole only while the output register is full and not taken
// reset: arst_n clears queue pointers and all valid bits at once; no clearing pass
`default_nettype none
module fixed_point_q24_8_alu_core (
	input  logic         clk,
	input  logic         arst_n,
	fxalu_cmd_if.sink    cmd_ch,
	fxalu_res_if.source  res_ch
);
	import fxalu_pkg::*;

	work_t front_item;
	logic  front_valid;
	logic  front_ready;
	work_t head;
	logic  head_valid;
	logic  head_pop;

	fxalu_front u_front (
		.cmd_ch     (cmd_ch),
		.item       (front_item),
		.item_valid (front_valid),
		.item_ready (front_ready)
	);

	fxalu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_item  (front_item),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_item  (head),
		.rd_valid (head_valid),
		.rd_pop   (head_pop)
	);

	fxalu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (head_pop),
		.res_ch     (res_ch)
	);

endmodule
`default_nettype wire

// ===== tb/sv/fxalu_checker.sv =====
module fxalu_checker (
	input  logic        clk,
	input  logic        arst_n,
	fxalu_cmd_if.sink   cmd_mon,
	fxalu_res_if.sink   res_mon,
	output int          fail_count,
	output int          pending_count,
	output int          result_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import fxalu_pkg::*;

	res_item_t expected_results[$];
	int        result_tally;

	// saturating fit of a sign and a wide magnitude
	function automatic logic [31:0] fit_word(input logic neg, input logic [127:0] mag,
			inout logic [1:0] st);
		logic [127:0] lim;
		lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
		if (mag > lim) begin
			st = ST_OVF;
			return neg ? MinNeg : MaxPos;
		end
		return neg ? 32'(-mag) : mag[31:0];
	endfunction

	// compute the result of one command exactly
	function automatic res_item_t alu_result(input cmd_item_t c);
		res_item_t    r;
		logic signed [31:0] a, b;
		logic [31:0]  ma, mb;
		logic signed [32:0] s;
		logic [127:0] p, q, n, rem;
		logic         neg;
		a = c.operand_a;
		b = c.operand_b;
		r = '0;
		ma = a[31] ? 32'(-a) : a;
		mb = b[31] ? 32'(-b) : b;
		neg = a[31] ^ b[31];
		case (c.command)
			CMD_ADD, CMD_SUB: begin
				s = (c.command == CMD_ADD) ? (33'(a) + 33'(b)) : (33'(a) - 33'(b));
				if (s > 33'sh0_7fff_ffff) begin
					r.result_value = MaxPos; r.status = ST_OVF;
				end else if (s < -33'sh0_8000_0000) begin
					r.result_value = MinNeg; r.status = ST_OVF;
				end else r.result_value = s[31:0];
			end
			CMD_MUL: begin
				p = (128'(ma) * 128'(mb) + (128'd1 << (FracBits - 1))) >> FracBits;
				if (p != 0) r.result_value = fit_word(neg, p, r.status);
			end
			CMD_DIV: begin
				if (mb == 0) begin
					r.status = ST_DIV0;
					if (ma != 0) r.result_value = a[31] ? MinNeg : MaxPos;
				end else begin
					n = 128'(ma) << FracBits;
					q = n / mb;
					rem = n % mb;
					if (rem >= 128'(mb) - rem) q = q + 1;
					if (q != 0) r.result_value = fit_word(neg, q, r.status);
				end
			end
			CMD_GT: r.compare_true = a > b;
			CMD_LT: r.compare_true = a < b;
			CMD_GE: r.compare_true = a >= b;
			CMD_LE: r.compare_true = a <= b;
			CMD_EQ: r.compare_true = a == b;
			CMD_NE: r.compare_true = a != b;
			CMD_MAX: r.result_value = (a > b) ? a : b;
			CMD_MIN: r.result_value = (a < b) ? a : b;
			CMD_INC: begin
				if (a == MaxPos) begin
					r.result_value = MaxPos; r.status = ST_OVF;
				end else r.result_value = a + 1;
			end
			CMD_TO_INT: r.result_value = a >>> FracBits;
			CMD_FROM_INT: begin
				if (a > (32'sh7fff_ffff >>> FracBits)) begin
					r.result_value = MaxPos; r.status = ST_OVF;
				end else if (a < (-32'sh8000_0000 >>> FracBits)) begin
					r.result_value = MinNeg; r.status = ST_OVF;
				end else r.result_value = a <<< FracBits;
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		result_tally = 0;
	end

	assign pending_count = expected_results.size();
	assign result_count = result_tally;

	// predict on accepted commands, check accepted results
	always @(posedge clk) begin
		res_item_t want, got;
		if (arst_n) begin
			if (cmd_mon.valid && cmd_mon.ready)
				expected_results.push_back(alu_result(cmd_mon.payload));
			if (res_mon.valid && res_mon.ready) begin
				got = res_mon.payload;
				result_tally++;
				if (expected_results.size() == 0) begin
					report("unexpected result", got.result_value, '0);
				end else begin
					want = expected_results.pop_front();
					if (got.result_value !== want.result_value)
						report("result_value", got.result_value, want.result_value);
					if (got.compare_true !== want.compare_true)
						report("compare_true", 32'(got.compare_true), 32'(want.compare_true));
					if (got.status !== want.status)
						report("status", 32'(got.status), 32'(want.status));
				end
			end
		end
	end
endmodule

// ===== tb/sv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fxalu_pkg::*;

	localparam int RandomItems = 1650;
	localparam int CycleLimit  = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending_count, result_count;
	int   cycles = 0;
	int   sent = 0;

	fxalu_cmd_if cmd_ch ();
	fxalu_res_if res_ch ();

	fixed_point_q24_8_alu_core dut (.clk(clk), .arst_n(arst_n), .cmd_ch(cmd_ch), .res_ch(res_ch));
	fxalu_checker checker_i (.clk(clk), .arst_n(arst_n), .cmd_mon(cmd_ch), .res_mon(res_ch),
		.fail_count(fail_count), .pending_count(pending_count), .result_count(result_count));

	always #1 clk = ~clk;

	// timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("fixed_point_q24_8_alu_core regression: fail");
			$finish;
		end
	end

	// result side stalls at random, with calm stretches
	initial begin
		int gap;
		res_ch.ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			if ((cycles / 2000) % 3 == 1) gap = 0;
			repeat (gap) @(posedge clk) res_ch.ready <= 1'b0;
			@(posedge clk) res_ch.ready <= 1'b1;
			while (!(res_ch.valid && res_ch.ready)) @(posedge clk);
		end
	end

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return MaxPos;
			1: return MinNeg;
			2: return 32'($signed($urandom_range(0, 2048)) - 1024);
			3: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
			4: return {$urandom_range(0, 1) ? 24'hffffff : 24'h0, 8'($urandom)};
			5: return 32'd0;
			default: return $urandom;
		endcase
	endfunction

	// called at a rising edge; returns after the first edge past which ready reads high
	task automatic send_command(input logic [3:0] command, input logic [31:0] a,
			input logic [31:0] b, input bit with_gap);
		int gap;
		gap = with_gap ? $urandom_range(0, 18) : 0;
		if (with_gap && $urandom_range(0, 2) == 0) gap = 0;
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.payload <= '{command: command, operand_a: a, operand_b: b};
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		sent++;
	endtask

	// stimulus
	initial begin
		logic [3:0] c;
		cmd_ch.valid = 1'b0;
		cmd_ch.payload = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed corners
		send_command(CMD_ADD, MaxPos, 32'd1, 0);
		send_command(CMD_SUB, MinNeg, 32'd1, 0);
		send_command(CMD_MUL, MaxPos, MaxPos, 0);
		send_command(CMD_MUL, 32'hffff_ff80, 32'h0000_0001, 1);
		send_command(CMD_MUL, 32'h0000_0080, 32'h0000_0001, 0);
		send_command(CMD_DIV, 32'h0000_0100, 32'd0, 0);
		send_command(CMD_DIV, MinNeg, 32'd0, 0);
		send_command(CMD_DIV, 32'd0, 32'd0, 1);
		send_command(CMD_DIV, MinNeg, 32'hffff_ffff, 0);
		send_command(CMD_DIV, 32'd1, 32'd2, 0);
		send_command(CMD_GT, MaxPos, MinNeg, 0);
		send_command(CMD_LT, MinNeg, MaxPos, 1);
		send_command(CMD_GE, 32'd5, 32'd5, 0);
		send_command(CMD_LE, 32'hffff_ffff, 32'd0, 0);
		send_command(CMD_EQ, MinNeg, MinNeg, 0);
		send_command(CMD_NE, 32'd1, 32'd2, 1);
		send_command(CMD_MAX, 32'd7, 32'd7, 0);
		send_command(CMD_MIN, MinNeg, MaxPos, 0);
		send_command(CMD_INC, MaxPos, 32'd0, 0);
		send_command(CMD_TO_INT, MinNeg, 32'd0, 1);
		send_command(CMD_FROM_INT, 32'h0080_0000, 32'd0, 0);
		send_command(CMD_FROM_INT, 32'hff80_0000, 32'd0, 0);
		send_command(CMD_FROM_INT, 32'h007f_ffff, 32'd0, 0);
		send_command(4'd15, 32'hffff_ffff, 32'hffff_ffff, 1);
		// random mix, with gap-free stretches
		for (int i = 0; i < RandomItems; i++) begin
			c = ($urandom_range(0, 15) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
			send_command(c, pick_operand(), pick_operand(), (i / 200) % 3 != 1);
		end
		cmd_ch.valid <= 1'b0;
		while (pending_count != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		$display("sent %0d commands over all 15 codes plus the unused one; checked %0d results",
			sent, result_count);
		if (fail_count == 0)
			$display("fixed_point_q24_8_alu_core regression: pass");
		else
			$display("fixed_point_q24_8_alu_core regression: fail");
		$finish;
	end
endmodule
